// ===== rtl/core/rtt_pkg.sv =====
// shared types, codes and helpers for the retransmission timeout estimator
package rtt_pkg;

    localparam int unsigned MS_W   = 32;
    localparam int unsigned GRAN_W = 16;
    localparam int unsigned HOLD_W = MS_W + 1;
    localparam int unsigned ADDR_W = 4;

    localparam logic [MS_W-1:0]   RESET_INITIAL_RTO = 32'd1000;
    localparam logic [MS_W-1:0]   RESET_MIN_RTO     = 32'd200;
    localparam logic [MS_W-1:0]   RESET_MAX_RTO     = 32'd60000;
    localparam logic [GRAN_W-1:0] RESET_GRANULARITY = 16'd1;
    // clamp of the reset initial rto against the reset limits
    localparam logic [MS_W-1:0]   RESET_RTO         = 32'd1000;

    typedef enum logic [1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_TIMEOUT = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_INITIAL_RTO = 2'd0,
        REG_MIN_RTO     = 2'd1,
        REG_MAX_RTO     = 2'd2,
        REG_GRANULARITY = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MS_W-1:0]   initial_rto;
        logic [MS_W-1:0]   min_rto;
        logic [MS_W-1:0]   max_rto;
        logic [GRAN_W-1:0] granularity;
    } t_cfg;

    typedef struct packed {
        logic [MS_W-1:0]   srtt;
        logic [MS_W-1:0]   rttvar;
        logic              have_sample;
        logic [MS_W-1:0]   rto;
        logic              hold_active;
        logic [HOLD_W-1:0] hold_until;
    } t_est_state;

    // clamp a wide candidate into [max(1,min), max(eff min,max)]
    function automatic logic [MS_W-1:0] clamp_rto(
        input logic [MS_W+2:0] v,
        input logic [MS_W-1:0] min_rto,
        input logic [MS_W-1:0] max_rto
    );
        logic [MS_W-1:0] lo;
        logic [MS_W-1:0] hi;
        logic [MS_W-1:0] res;
        lo = (min_rto == '0) ? {{(MS_W-1){1'b0}}, 1'b1} : min_rto;
        hi = (max_rto < lo) ? lo : max_rto;
        if (v < {3'b000, lo}) begin
            res = lo;
        end else if (v > {3'b000, hi}) begin
            res = hi;
        end else begin
            res = v[MS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/rtt_cfg.sv =====
// apb register file holding the estimator limits and initial rto
module rtt_cfg
    import rtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [MS_W-1:0]   pwdata,
    output logic [MS_W-1:0]   prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_rto <= RESET_INITIAL_RTO;
            r_cfg.min_rto     <= RESET_MIN_RTO;
            r_cfg.max_rto     <= RESET_MAX_RTO;
            r_cfg.granularity <= RESET_GRANULARITY;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INITIAL_RTO: r_cfg.initial_rto <= pwdata;
                REG_MIN_RTO:     r_cfg.min_rto     <= pwdata;
                REG_MAX_RTO:     r_cfg.max_rto     <= pwdata;
                REG_GRANULARITY: r_cfg.granularity <= pwdata[GRAN_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INITIAL_RTO: prdata = r_cfg.initial_rto;
            REG_MIN_RTO:     prdata = r_cfg.min_rto;
            REG_MAX_RTO:     prdata = r_cfg.max_rto;
            REG_GRANULARITY: prdata = {{(MS_W-GRAN_W){1'b0}}, r_cfg.granularity};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/rtt_core.sv =====
// next-state logic: rtt filter update, backoff and restart
module rtt_core
    import rtt_pkg::*;
(
    input  t_cfg            i_cfg,
    input  t_est_state      i_state,
    input  t_mode           i_mode,
    input  logic [MS_W-1:0] i_sample_ms,
    input  logic [MS_W-1:0] i_now_ms,
    output t_est_state      o_state,
    output logic            o_backoff_applied
);

    logic [MS_W-1:0]   w_sample;
    logic [MS_W-1:0]   w_dev;
    logic [MS_W+1:0]   w_var_sum;
    logic [MS_W+2:0]   w_srtt_sum;
    logic [MS_W-1:0]   w_srtt_n;
    logic [MS_W-1:0]   w_var_n;
    logic [MS_W+1:0]   w_term;
    logic [MS_W+1:0]   w_term_m;
    logic [MS_W+2:0]   w_rto_sum;
    logic [MS_W-1:0]   w_rto_sample;
    logic [MS_W-1:0]   w_rto_double;
    logic [HOLD_W-1:0] w_hold_end;
    logic              w_suppress;

    // sample path
    assign w_sample = (i_sample_ms == '0) ? {{(MS_W-1){1'b0}}, 1'b1} : i_sample_ms;
    assign w_dev    = (i_state.srtt > w_sample) ? i_state.srtt - w_sample
                                                : w_sample - i_state.srtt;
    // 3*var + dev and 7*srtt + sample, both at full width
    assign w_var_sum  = {1'b0, i_state.rttvar, 1'b0} + {2'b00, i_state.rttvar}
                      + {2'b00, w_dev};
    assign w_srtt_sum = {i_state.srtt, 3'b000} - {3'b000, i_state.srtt}
                      + {3'b000, w_sample};

    always_comb begin
        if (i_state.have_sample) begin
            w_srtt_n = w_srtt_sum[MS_W+2:3];
            w_var_n  = w_var_sum[MS_W+1:2];
        end else begin
            w_srtt_n = w_sample;
            w_var_n  = {1'b0, w_sample[MS_W-1:1]};
        end
    end

    assign w_term       = {w_var_n, 2'b00};
    assign w_term_m     = (w_term < {{(MS_W+2-GRAN_W){1'b0}}, i_cfg.granularity})
                        ? {{(MS_W+2-GRAN_W){1'b0}}, i_cfg.granularity} : w_term;
    assign w_rto_sum    = {3'b000, w_srtt_n} + {1'b0, w_term_m};
    assign w_rto_sample = clamp_rto(w_rto_sum, i_cfg.min_rto, i_cfg.max_rto);

    // timeout path
    assign w_suppress   = i_state.hold_active
                        & ({1'b0, i_now_ms} < i_state.hold_until);
    assign w_rto_double = clamp_rto({2'b00, i_state.rto, 1'b0},
                                    i_cfg.min_rto, i_cfg.max_rto);
    assign w_hold_end   = {1'b0, i_now_ms} + {1'b0, w_rto_double};

    always_comb begin
        o_state           = i_state;
        o_backoff_applied = 1'b0;
        case (i_mode)
            MODE_SAMPLE: begin
                o_state.srtt        = w_srtt_n;
                o_state.rttvar      = w_var_n;
                o_state.have_sample = 1'b1;
                o_state.rto         = w_rto_sample;
                o_state.hold_active = 1'b0;
                o_state.hold_until  = '0;
            end
            MODE_TIMEOUT: begin
                if (!w_suppress) begin
                    o_state.rto         = w_rto_double;
                    o_state.hold_until  = w_hold_end;
                    o_state.hold_active = 1'b1;
                    o_backoff_applied   = 1'b1;
                end
            end
            MODE_RESTART: begin
                o_state.srtt        = '0;
                o_state.rttvar      = '0;
                o_state.have_sample = 1'b0;
                o_state.hold_active = 1'b0;
                o_state.hold_until  = '0;
                o_state.rto         = clamp_rto({3'b000, i_cfg.initial_rto},
                                                i_cfg.min_rto, i_cfg.max_rto);
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ===== rtl/core/rtt_retransmit_timeout_estimator.sv =====
// top level: input register, estimator state, result register and apb port
// Integer retransmission timeout estimator in the style of the standard tcp
// rto algorithm. Each input word carries a mode (rtt sample, timeout, restart)
// and returns exactly one result word with the current rto and a flag that
// tells whether a timeout doubled it. Throughput is one word per clock while
// the result side is not stalled: the input register feeds a single pass of
// next-state logic (filter update, clamp, doubling and hold compare) that
// writes the estimator state and the result register at the same edge, so the
// next word already sees the new state. An accepted word is held in the input
// register and its result in the result register; a stalled result register
// backs up into the input register and then into o_ready.
// The apb registers (initial rto, min rto, max rto, clock granularity at byte
// offsets 0, 4, 8, 12) are read live at every clamp; writing them does not
// touch the state, and a restart word loads the clamped initial rto. Write
// them only while no word is in flight. After reset the rto is 1000 ms and
// the limits are 200 ms and 60000 ms with 1 ms granularity.
module rtt_retransmit_timeout_estimator
    import rtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [MS_W-1:0]   i_sample_ms,
    input  logic [MS_W-1:0]   i_now_ms,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MS_W-1:0]   o_rto_ms,
    output logic              o_backoff_applied,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [MS_W-1:0]   pwdata,
    output logic [MS_W-1:0]   prdata,
    output logic              pready
);

    t_cfg            w_cfg;
    t_est_state      r_state;
    t_est_state      n_state;
    logic            n_applied;

    // input register
    logic            r_in_valid;
    t_mode           r_mode;
    logic [MS_W-1:0] r_sample;
    logic [MS_W-1:0] r_now;

    // result register
    logic            r_out_valid;
    logic [MS_W-1:0] r_rto;
    logic            r_applied;

    logic            w_advance;
    logic            w_in_take;

    // a word moves to the result register when the result slot is free or
    // is being emptied in this same cycle
    assign w_advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready   = ~r_in_valid | w_advance;
    assign w_in_take = i_valid & o_ready;

    assign o_valid           = r_out_valid;
    assign o_rto_ms          = r_rto;
    assign o_backoff_applied = r_applied;

    rtt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rtt_core u_core (
        .i_cfg             (w_cfg),
        .i_state           (r_state),
        .i_mode            (r_mode),
        .i_sample_ms       (r_sample),
        .i_now_ms          (r_now),
        .o_state           (n_state),
        .o_backoff_applied (n_applied)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_mode   <= t_mode'(i_mode);
            r_sample <= i_sample_ms;
            r_now    <= i_now_ms;
        end
    end

    // estimator state, updated once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.srtt        <= '0;
            r_state.rttvar      <= '0;
            r_state.have_sample <= 1'b0;
            r_state.rto         <= RESET_RTO;
            r_state.hold_active <= 1'b0;
            r_state.hold_until  <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_rto     <= n_state.rto;
            r_applied <= n_applied;
        end
    end

    // rto never drops to zero, every clamp floors it at one
    a_rto_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.rto != '0)
        else $error("rto reached zero");

    // a cleared hold leaves no stale hold end behind
    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.hold_active |-> r_state.hold_until == '0)
        else $error("hold end set while hold inactive");

    // filter state is zero until the first sample
    a_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.have_sample |-> (r_state.srtt == '0 && r_state.rttvar == '0))
        else $error("filter state without a sample");

    // a sample word always ends any backoff hold
    a_sample_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_mode == MODE_SAMPLE) |=> !r_state.hold_active)
        else $error("hold survived a sample");

    // the backoff flag is only raised by a timeout word
    a_flag_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_mode != MODE_TIMEOUT) |=> !r_applied)
        else $error("backoff flag on a non-timeout word");

endmodule

// ===== bench/rtt_retransmit_timeout_estimator_tb.sv =====
// self-checking testbench for the retransmission timeout estimator: directed and random words
module rtt_retransmit_timeout_estimator_tb;
    import rtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result word
    typedef struct {
        logic [MS_W-1:0] rto;
        logic            applied;
    } t_rto_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_mode;
    logic [MS_W-1:0]   i_sample_ms;
    logic [MS_W-1:0]   i_now_ms;
    logic              o_valid;
    logic              i_ready;
    logic [MS_W-1:0]   o_rto_ms;
    logic              o_backoff_applied;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [MS_W-1:0]   pwdata;
    logic [MS_W-1:0]   prdata;
    logic              pready;

    // shadow copy of the registers
    logic [MS_W-1:0]   cfg_initial;
    logic [MS_W-1:0]   cfg_min;
    logic [MS_W-1:0]   cfg_max;
    logic [GRAN_W-1:0] cfg_gran;

    // shadow copy of the estimator state
    logic [MS_W-1:0]   est_srtt;
    logic [MS_W-1:0]   est_var;
    logic              est_have;
    logic [MS_W-1:0]   est_rto;
    logic              est_hold;
    logic [HOLD_W-1:0] est_hold_until;

    t_rto_word         pending_rto_q[$];
    int unsigned       errors = 0;
    bit                allow_idle = 1'b0;
    int unsigned       stall_left = 0;
    logic [MS_W-1:0]   wall_ms = '0;

    rtt_retransmit_timeout_estimator u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // estimator prediction
    // ------------------------------------------------------------------

    // clamp a wide value into [max(1,min), max(eff min,max)], limits read live
    function automatic logic [MS_W-1:0] bound_rto(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = (cfg_min == '0) ? 64'd1 : {32'd0, cfg_min};
        hi = ({32'd0, cfg_max} < lo) ? lo : {32'd0, cfg_max};
        if (v < lo) begin
            return lo[MS_W-1:0];
        end else if (v > hi) begin
            return hi[MS_W-1:0];
        end
        return v[MS_W-1:0];
    endfunction

    function automatic void restart_estimator();
        est_srtt       = '0;
        est_var        = '0;
        est_have       = 1'b0;
        est_hold       = 1'b0;
        est_hold_until = '0;
        est_rto        = bound_rto({32'd0, cfg_initial});
    endfunction

    // apply one word to the shadow state and return the word the block must answer
    function automatic t_rto_word advance_estimator(input t_mode mode,
                                                    input logic [MS_W-1:0] sample,
                                                    input logic [MS_W-1:0] now);
        logic [63:0] s;
        logic [63:0] dev;
        logic [63:0] term;
        logic [63:0] acc;
        t_rto_word   w;
        w.applied = 1'b0;
        case (mode)
            MODE_SAMPLE: begin
                // a zero sample counts as 1 ms
                s = (sample == '0) ? 64'd1 : {32'd0, sample};
                if (!est_have) begin
                    est_srtt = s[MS_W-1:0];
                    est_var  = s[MS_W:1];
                    est_have = 1'b1;
                end else begin
                    dev = ({32'd0, est_srtt} > s) ? {32'd0, est_srtt} - s
                                                   : s - {32'd0, est_srtt};
                    acc      = (64'd3 * {32'd0, est_var} + dev) >> 2;
                    est_var  = acc[MS_W-1:0];
                    acc      = (64'd7 * {32'd0, est_srtt} + s) >> 3;
                    est_srtt = acc[MS_W-1:0];
                end
                // full-width sum, never wraps before the clamp
                term = 64'd4 * {32'd0, est_var};
                if (term < {48'd0, cfg_gran}) begin
                    term = {48'd0, cfg_gran};
                end
                est_rto        = bound_rto(term + {32'd0, est_srtt});
                est_hold       = 1'b0;
                est_hold_until = '0;
            end
            MODE_TIMEOUT: begin
                // suppressed while the hold window is still open
                if (!(est_hold && ({1'b0, now} < est_hold_until))) begin
                    est_rto        = bound_rto({31'd0, est_rto, 1'b0});
                    est_hold_until = {1'b0, now} + {1'b0, est_rto};
                    est_hold       = 1'b1;
                    w.applied      = 1'b1;
                end
            end
            MODE_RESTART: begin
                restart_estimator();
            end
            default: begin
                // unused mode leaves everything as it is
            end
        endcase
        w.rto = est_rto;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall bursts and the word checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!allow_idle) begin
            i_ready    <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 6) == 0) begin
            // start a stall burst
            i_ready    <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rto_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rto_q.size() == 0) begin
                $error("unexpected word: rto_ms %0d backoff_applied %0b",
                       o_rto_ms, o_backoff_applied);
                errors++;
            end else begin
                want = pending_rto_q.pop_front();
                if (o_rto_ms !== want.rto) begin
                    $error("rto_ms: expected %0d, got %0d", want.rto, o_rto_ms);
                    errors++;
                end
                if (o_backoff_applied !== want.applied) begin
                    $error("backoff_applied: expected %0b, got %0b",
                           want.applied, o_backoff_applied);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side and register access
    // ------------------------------------------------------------------

    // present one word, hold it until accepted, then maybe leave a gap
    task automatic send_event(input t_mode mode, input logic [MS_W-1:0] sample,
                              input logic [MS_W-1:0] now);
        int unsigned gap;
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_sample_ms <= sample;
        i_now_ms    <= now;
        do @(posedge i_clk); while (!o_ready);
        pending_rto_q.push_back(advance_estimator(mode, sample, now));
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding word come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_rto_q.size() != 0) @(posedge i_clk);
        // two-register pipeline, a little margin on top
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle (pready is always high)
    task automatic write_reg(input t_reg_idx idx, input logic [MS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INITIAL_RTO: cfg_initial = value;
            REG_MIN_RTO:     cfg_min     = value;
            REG_MAX_RTO:     cfg_max     = value;
            REG_GRANULARITY: cfg_gran    = value[GRAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [MS_W-1:0] initial_rto, input logic [MS_W-1:0] min_rto,
                              input logic [MS_W-1:0] max_rto, input logic [GRAN_W-1:0] gran);
        write_reg(REG_INITIAL_RTO, initial_rto);
        write_reg(REG_MIN_RTO, min_rto);
        write_reg(REG_MAX_RTO, max_rto);
        write_reg(REG_GRANULARITY, {16'd0, gran});
    endtask

    // one random word, mostly samples and timeouts on a running clock
    task automatic send_random_event(input logic [MS_W-1:0] sample_hi);
        int unsigned     pick;
        logic [MS_W-1:0] sample;
        logic [MS_W-1:0] now;
        pick   = $urandom_range(0, 99);
        sample = $urandom;
        now    = $urandom;
        if (pick < 50) begin
            case ($urandom_range(0, 9))
                0:       sample = '0;
                1, 2:    sample = $urandom;
                default: sample = $urandom_range(0, sample_hi);
            endcase
            send_event(MODE_SAMPLE, sample, now);
        end else if (pick < 88) begin
            wall_ms = wall_ms + $urandom_range(0, sample_hi);
            case ($urandom_range(0, 9))
                0: begin
                    now = $urandom;
                end
                1, 2, 3: begin
                    // land right around the hold end to hit both sides of the compare
                    if (est_hold && !est_hold_until[HOLD_W-1]) begin
                        now = est_hold_until[MS_W-1:0] + $urandom_range(0, 6) - 3;
                    end else begin
                        now = wall_ms;
                    end
                end
                default: begin
                    now = wall_ms;
                end
            endcase
            send_event(MODE_TIMEOUT, sample, now);
        end else if (pick < 96) begin
            send_event(MODE_RESTART, sample, now);
        end else begin
            send_event(MODE_NONE, sample, now);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset limits: unused mode, hold window, zero and max samples, restart
    task automatic test_reset_state();
        allow_idle = 1'b1;
        send_event(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(MODE_TIMEOUT, '0, 32'd0);
        // one before the hold end is suppressed, at the hold end doubles
        send_event(MODE_TIMEOUT, '0, 32'd1999);
        send_event(MODE_TIMEOUT, '0, 32'd2000);
        send_event(MODE_SAMPLE, 32'd0, '0);
        send_event(MODE_SAMPLE, 32'hFFFF_FFFF, '0);
        send_event(MODE_SAMPLE, 32'd100, '0);
        // hold end past 32 bits, so a wrapped now stays inside the window
        send_event(MODE_TIMEOUT, '0, 32'hFFFF_FFFF);
        send_event(MODE_TIMEOUT, '0, 32'd0);
        send_event(MODE_RESTART, '0, '0);
        // first sample at max width: sum overflows 32 bits before the clamp
        send_event(MODE_SAMPLE, 32'hFFFF_FFFF, '0);
        send_event(MODE_NONE, '0, '0);
        wait_idle();
    endtask

    // zero limits, widest limits and a minimum above the maximum
    task automatic test_limit_extremes();
        set_limits('0, '0, '0, '0);
        send_event(MODE_RESTART, '0, '0);
        send_event(MODE_SAMPLE, 32'd0, '0);
        send_event(MODE_TIMEOUT, '0, 32'd5);
        wait_idle();
        set_limits(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(MODE_RESTART, '0, '0);
        send_event(MODE_TIMEOUT, '0, 32'hFFFF_FFFF);
        send_event(MODE_TIMEOUT, '0, 32'd0);
        send_event(MODE_SAMPLE, 32'd0, '0);
        send_event(MODE_SAMPLE, 32'hFFFF_FFFF, '0);
        send_event(MODE_TIMEOUT, '0, 32'h8000_0000);
        wait_idle();
        set_limits(32'd1000, 32'd5000, 32'd100, '0);
        send_event(MODE_RESTART, '0, '0);
        send_event(MODE_TIMEOUT, '0, 32'd0);
        send_event(MODE_SAMPLE, 32'd7, '0);
        wait_idle();
    endtask

    // random phases, each with fresh limits; every phase starts from an empty pipe
    task automatic test_random_traffic(input int unsigned phases,
                                       input int unsigned words_per_phase);
        logic [MS_W-1:0] sample_hi;
        for (int unsigned p = 0; p < phases; p++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: set_limits(RESET_INITIAL_RTO, RESET_MIN_RTO, RESET_MAX_RTO,
                              RESET_GRANULARITY);
                1: set_limits($urandom_range(0, 3000), $urandom_range(0, 500),
                              $urandom_range(500, 100000), 16'($urandom_range(0, 50)));
                2: set_limits($urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)));
                3: set_limits($urandom_range(0, 8000), $urandom_range(1000, 5000),
                              $urandom_range(0, 999), 16'($urandom_range(0, 200)));
                default: set_limits($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, '0,
                                    32'hFFFF_FFFF,
                                    $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            endcase
            case ($urandom_range(0, 2))
                0:       sample_hi = 32'd200;
                1:       sample_hi = 32'd5000;
                default: sample_hi = 32'd200000;
            endcase
            // some phases run with no idling at all
            allow_idle = ($urandom_range(0, 3) != 0);
            // a skipped restart keeps old state under the new limits
            if ($urandom_range(0, 3) != 0) begin
                send_event(MODE_RESTART, $urandom, $urandom);
            end
            repeat (words_per_phase) send_random_event(sample_hi);
        end
        wait_idle();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate_tail();
        allow_idle = 1'b0;
        set_limits(RESET_INITIAL_RTO, RESET_MIN_RTO, RESET_MAX_RTO, RESET_GRANULARITY);
        send_event(MODE_RESTART, '0, '0);
        repeat (160) send_random_event(32'd5000);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        int unsigned guard;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = MODE_NONE;
        i_sample_ms = '0;
        i_now_ms    = '0;
        i_ready     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;

        // reset values of the registers and the estimator
        cfg_initial = RESET_INITIAL_RTO;
        cfg_min     = RESET_MIN_RTO;
        cfg_max     = RESET_MAX_RTO;
        cfg_gran    = RESET_GRANULARITY;
        restart_estimator();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_limit_extremes();
        test_random_traffic(8, 190);
        test_full_rate_tail();

        // drain with a bound, then let the pipe settle
        i_valid <= 1'b0;
        guard = 0;
        while (pending_rto_q.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_rto_q.size() != 0) begin
            $error("%0d expected rto words never arrived", pending_rto_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("rtt_retransmit_timeout_estimator_tb: clean");
        end else begin
            $display("rtt_retransmit_timeout_estimator_tb: errors");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("rtt_retransmit_timeout_estimator_tb: errors");
        $finish;
    end

endmodule
